// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define JV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define JV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/jvrl_pkg.sv =====
package jvrl_pkg;

  // Axis count and field widths.
  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = 2;
  localparam int CMD_W      = 16;
  localparam int VEL_W      = 32;
  localparam int POS_W      = 48;
  localparam int SPEED_W    = 31;
  localparam int STEP_W     = 31;
  localparam int DZ_W       = 15;
  localparam int LEAD_W     = 40;
  localparam int PCT_W      = 7;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  // Request opcodes.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_LIMIT = 2'd3;

  // Configuration reset values.
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 31'd200000000;
  localparam logic [STEP_W-1:0]  VEL_STEP_RST   = 31'd100000;
  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST  = 15'd1638;
  localparam logic [LEAD_W-1:0]  LEAD_LIMIT_RST = 40'd10000000000;

  // Stick and D-pad thresholds, Q1.15.
  localparam logic signed [CMD_W-1:0] Z_TRIG_LIMIT = 16'sd29491;
  localparam logic signed [CMD_W-1:0] DPAD_HI      = 16'sd16384;
  localparam logic signed [CMD_W-1:0] DPAD_LO      = -16'sd16384;
  localparam logic signed [CMD_W-1:0] CMD_POS_MAX  = 16'sd32767;

  // Speed percentage limits.
  localparam logic [PCT_W-1:0] PCT_STEP = 7'd5;
  localparam logic [PCT_W-1:0] PCT_MIN  = 7'd5;
  localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;

  // Percent divider: 40-bit dividend, eight quotient bits per cycle.
  localparam int DIV_W       = 40;
  localparam int DIV_BITS    = 8;
  localparam int DIV_STEPS   = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W   = 3;
  localparam logic [7:0] PCT_DIVISOR = 8'd100;

  // Position range limits.
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_AX_MUL,
    ST_AX_RAMP,
    ST_AX_LEASH,
    ST_EMIT
  } jvrl_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic              frame_ld;
    logic              tick_ld;
    logic              mul_go;
    logic              div_step;
    logic              ax_mul;
    logic              ax_ramp;
    logic              ax_leash;
    logic              out_ld;
    logic [AXIS_W-1:0] axis;
  } jvrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_last;
  } jvrl_status_t;

endpackage

// ===== rtl/jog_velocity_ramp_leash.sv =====
// Channel   Direction  Handshake          Payload
// in_*      request    in_valid/in_stall  op, axes, triggers, D-pad, pose
// out_*     result     out_valid/out_stall goal_x/y/z, speed_pct
// cfg_*     write      cfg_wr_en          cfg_index, cfg_data
//
// A joystick frame or a tick without a pose is taken while idle and leaves
// the block idle. A tick with a pose holds off the next request while it is
// accepted, the speed product is formed, the divide by 100 runs (eight
// quotient bits a cycle), each axis goes through the one shared multiply,
// ramp and leash unit in three steps, then the result register is loaded;
// a held result stalls that load, and frames wait too. Reset is synchronous.
module jog_velocity_ramp_leash (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic                                in_axes_present,
  input  logic signed [jvrl_pkg::CMD_W-1:0]   in_stick_fwd,
  input  logic signed [jvrl_pkg::CMD_W-1:0]   in_stick_side,
  input  logic signed [jvrl_pkg::CMD_W-1:0]   in_trigger_left,
  input  logic signed [jvrl_pkg::CMD_W-1:0]   in_trigger_right,
  input  logic signed [jvrl_pkg::CMD_W-1:0]   in_dpad_axis,
  input  logic                                in_pose_valid,
  input  logic signed [jvrl_pkg::POS_W-1:0]   in_meas_x,
  input  logic signed [jvrl_pkg::POS_W-1:0]   in_meas_y,
  input  logic signed [jvrl_pkg::POS_W-1:0]   in_meas_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [jvrl_pkg::POS_W-1:0]   out_goal_x,
  output logic signed [jvrl_pkg::POS_W-1:0]   out_goal_y,
  output logic signed [jvrl_pkg::POS_W-1:0]   out_goal_z,
  output logic [jvrl_pkg::PCT_W-1:0]          out_speed_pct,
  input  logic                                cfg_wr_en,
  input  logic [jvrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jvrl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import jvrl_pkg::*;

  logic [SPEED_W-1:0] max_speed_r;
  logic [STEP_W-1:0]  vel_step_r;
  logic [DZ_W-1:0]    dead_zone_r;
  logic [LEAD_W-1:0]  lead_limit_r;

  jvrl_cmd_t    cmd;
  jvrl_status_t status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= MAX_SPEED_RST;
      vel_step_r   <= VEL_STEP_RST;
      dead_zone_r  <= DEAD_ZONE_RST;
      lead_limit_r <= LEAD_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_SPEED:  max_speed_r  <= cfg_data[SPEED_W-1:0];
        CFG_VEL_STEP:   vel_step_r   <= cfg_data[STEP_W-1:0];
        CFG_DEAD_ZONE:  dead_zone_r  <= cfg_data[DZ_W-1:0];
        CFG_LEAD_LIMIT: lead_limit_r <= cfg_data[LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  jvrl_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_op         (in_op),
    .in_pose_valid (in_pose_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .cmd           (cmd)
  );

  jvrl_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .max_speed        (max_speed_r),
    .velocity_step    (vel_step_r),
    .dead_zone        (dead_zone_r),
    .lead_limit       (lead_limit_r),
    .in_axes_present  (in_axes_present),
    .in_stick_fwd     (in_stick_fwd),
    .in_stick_side    (in_stick_side),
    .in_trigger_left  (in_trigger_left),
    .in_trigger_right (in_trigger_right),
    .in_dpad_axis     (in_dpad_axis),
    .in_meas_x        (in_meas_x),
    .in_meas_y        (in_meas_y),
    .in_meas_z        (in_meas_z),
    .out_goal_x       (out_goal_x),
    .out_goal_y       (out_goal_y),
    .out_goal_z       (out_goal_z),
    .out_speed_pct    (out_speed_pct)
  );

endmodule

// ===== rtl/jvrl_datapath.sv =====
module jvrl_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  jvrl_pkg::jvrl_cmd_t                   cmd,
  output jvrl_pkg::jvrl_status_t                status,
  input  logic [jvrl_pkg::SPEED_W-1:0]          max_speed,
  input  logic [jvrl_pkg::STEP_W-1:0]           velocity_step,
  input  logic [jvrl_pkg::DZ_W-1:0]             dead_zone,
  input  logic [jvrl_pkg::LEAD_W-1:0]           lead_limit,
  input  logic                                  in_axes_present,
  input  logic signed [jvrl_pkg::CMD_W-1:0]     in_stick_fwd,
  input  logic signed [jvrl_pkg::CMD_W-1:0]     in_stick_side,
  input  logic signed [jvrl_pkg::CMD_W-1:0]     in_trigger_left,
  input  logic signed [jvrl_pkg::CMD_W-1:0]     in_trigger_right,
  input  logic signed [jvrl_pkg::CMD_W-1:0]     in_dpad_axis,
  input  logic signed [jvrl_pkg::POS_W-1:0]     in_meas_x,
  input  logic signed [jvrl_pkg::POS_W-1:0]     in_meas_y,
  input  logic signed [jvrl_pkg::POS_W-1:0]     in_meas_z,
  output logic signed [jvrl_pkg::POS_W-1:0]     out_goal_x,
  output logic signed [jvrl_pkg::POS_W-1:0]     out_goal_y,
  output logic signed [jvrl_pkg::POS_W-1:0]     out_goal_z,
  output logic [jvrl_pkg::PCT_W-1:0]            out_speed_pct
);
  import jvrl_pkg::*;

  // Per-axis state.
  logic signed [CMD_W-1:0] cmd_r  [NUM_AXES];
  logic signed [VEL_W-1:0] vel_r  [NUM_AXES];
  logic signed [POS_W-1:0] tgt_r  [NUM_AXES];
  logic signed [POS_W-1:0] meas_r [NUM_AXES];
  logic                    seeded_r;
  logic [PCT_W-1:0]        pct_r, pct_nxt;
  logic                    slower_prev_r, faster_prev_r;

  // Divider and shared axis unit registers.
  logic [DIV_W-1:0]        div_r, div_nxt;
  logic [6:0]              rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]    div_cnt_r;
  logic signed [POS_W-1:0] dprod_r;
  logic signed [POS_W-1:0] lo_r, hi_r;

  // Output payload registers.
  logic signed [POS_W-1:0] goal_x_r, goal_y_r, goal_z_r;
  logic [PCT_W-1:0]        speed_r;

  // Joystick frame decode.
  logic signed [17:0]      lt_diff, rt_diff;
  logic [CMD_W-1:0]        lt_half, rt_half;
  logic signed [CMD_W-1:0] z_cmd;
  logic                    slower, faster;
  logic [PCT_W-1:0]        pct_mid;

  assign lt_diff = 18'sd32768 - 18'(in_trigger_left);
  assign rt_diff = 18'sd32768 - 18'(in_trigger_right);
  assign lt_half = lt_diff[16:1];
  assign rt_half = rt_diff[16:1];
  assign slower  = in_dpad_axis > DPAD_HI;
  assign faster  = in_dpad_axis < DPAD_LO;

  always_comb begin
    if (in_trigger_left <= Z_TRIG_LIMIT) begin
      z_cmd = (lt_half > 16'd32767) ? CMD_POS_MAX : $signed(lt_half);
    end else if (in_trigger_right <= Z_TRIG_LIMIT) begin
      z_cmd = $signed(16'(-{1'b0, rt_half}));
    end else begin
      z_cmd = '0;
    end
  end

  // Speed percentage steps on rising D-pad edges.
  always_comb begin
    pct_mid = pct_r;
    if (slower && !slower_prev_r) begin
      pct_mid = (pct_r < PCT_MIN + PCT_STEP) ? PCT_MIN : pct_r - PCT_STEP;
    end
    pct_nxt = pct_mid;
    if (faster && !faster_prev_r) begin
      pct_nxt = (pct_mid > PCT_MAX - PCT_STEP) ? PCT_MAX : pct_mid + PCT_STEP;
    end
  end

  // Scaled maximum product, loaded into the divider shift register.
  logic [DIV_W-1:0] sp_prod;
  assign sp_prod = DIV_W'(max_speed) * DIV_W'(pct_r);

  // Long division by 100, eight quotient bits per cycle.
  logic [7:0]          rem_w;
  logic [DIV_BITS-1:0] qbits;
  always_comb begin
    rem_w = {1'b0, rem_r};
    qbits = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      rem_w = {rem_w[6:0], div_r[DIV_W-1-j]};
      if (rem_w >= PCT_DIVISOR) begin
        rem_w = rem_w - PCT_DIVISOR;
        qbits[DIV_BITS-1-j] = 1'b1;
      end
    end
    rem_nxt = rem_w[6:0];
    div_nxt = {div_r[DIV_W-DIV_BITS-1:0], qbits};
  end

  assign status.div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Axis unit, first step: desired velocity product and leash bounds.
  logic signed [CMD_W-1:0]  cmd_sel;
  logic signed [VEL_W-1:0]  vel_sel;
  logic signed [POS_W-1:0]  tgt_sel, meas_sel;
  logic signed [VEL_W-1:0]  vmax_s;
  logic signed [POS_W-1:0]  dprod_nxt;
  logic signed [POS_W:0]    lo_w, hi_w, lead_w;
  logic signed [POS_W-1:0]  lo_nxt, hi_nxt;

  assign cmd_sel   = cmd_r[cmd.axis];
  assign vel_sel   = vel_r[cmd.axis];
  assign tgt_sel   = tgt_r[cmd.axis];
  assign meas_sel  = meas_r[cmd.axis];
  assign vmax_s    = $signed({1'b0, div_r[SPEED_W-1:0]});
  assign dprod_nxt = cmd_sel * vmax_s;
  assign lead_w    = $signed({1'b0, (POS_W-LEAD_W)'(0), lead_limit});
  assign lo_w      = (POS_W+1)'(meas_sel) - lead_w;
  assign hi_w      = (POS_W+1)'(meas_sel) + lead_w;
  assign lo_nxt    = (lo_w < (POS_W+1)'(POS_MIN)) ? POS_MIN : lo_w[POS_W-1:0];
  assign hi_nxt    = (hi_w > (POS_W+1)'(POS_MAX)) ? POS_MAX : hi_w[POS_W-1:0];

  // Axis unit, second step: slew-limited ramp with dead zone.
  logic signed [POS_W-1:0] dprod_b;
  logic signed [32:0]      desired;
  logic signed [33:0]      err, step_w;
  logic [CMD_W:0]          cmd_mag;
  logic signed [VEL_W-1:0] vel_nxt;

  assign dprod_b = dprod_r + (dprod_r[POS_W-1] ? POS_W'(32767) : POS_W'(0));
  assign desired = dprod_b[POS_W-1:15];
  assign step_w  = $signed({3'b0, velocity_step});
  assign cmd_mag = cmd_sel[CMD_W-1] ? (CMD_W+1)'(-(CMD_W+1)'(cmd_sel))
                                    : (CMD_W+1)'(cmd_sel);

  always_comb begin
    err = 34'(desired) - 34'(vel_sel);
    if (err > step_w) begin
      err = step_w;
    end
    if (err < -step_w) begin
      err = -step_w;
    end
    if (cmd_mag < (CMD_W+1)'(dead_zone)) begin
      vel_nxt = '0;
    end else begin
      vel_nxt = VEL_W'(34'(vel_sel) + err);
    end
  end

  // Axis unit, third step: integrate and clamp to the leash.
  logic signed [POS_W:0]   t_w;
  logic signed [POS_W-1:0] tgt_nxt;
  assign t_w = (POS_W+1)'(tgt_sel) + (POS_W+1)'(vel_sel);

  always_comb begin
    if (t_w < (POS_W+1)'(lo_r)) begin
      tgt_nxt = lo_r;
    end else if (t_w > (POS_W+1)'(hi_r)) begin
      tgt_nxt = hi_r;
    end else begin
      tgt_nxt = t_w[POS_W-1:0];
    end
  end

  // State registers initialised by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        cmd_r[i] <= '0;
        vel_r[i] <= '0;
        tgt_r[i] <= '0;
      end
      seeded_r      <= 1'b0;
      pct_r         <= PCT_MAX;
      slower_prev_r <= 1'b0;
      faster_prev_r <= 1'b0;
      div_cnt_r     <= '0;
    end else begin
      // A frame reloads the commands and the D-pad edge state; without axes it clears the commands.
      if (cmd.frame_ld) begin
        if (in_axes_present) begin
          cmd_r[0]      <= in_stick_fwd;
          cmd_r[1]      <= in_stick_side;
          cmd_r[2]      <= z_cmd;
          pct_r         <= pct_nxt;
          slower_prev_r <= slower;
          faster_prev_r <= faster;
        end else begin
          for (int i = 0; i < NUM_AXES; i++) begin
            cmd_r[i] <= '0;
          end
        end
      end
      // The first tick with a pose seeds the targets.
      if (cmd.tick_ld && !seeded_r) begin
        tgt_r[0] <= in_meas_x;
        tgt_r[1] <= in_meas_y;
        tgt_r[2] <= in_meas_z;
        seeded_r <= 1'b1;
      end
      if (cmd.mul_go) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.ax_ramp) begin
        vel_r[cmd.axis] <= vel_nxt;
      end
      if (cmd.ax_leash) begin
        tgt_r[cmd.axis] <= tgt_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.tick_ld) begin
      meas_r[0] <= in_meas_x;
      meas_r[1] <= in_meas_y;
      meas_r[2] <= in_meas_z;
    end
    if (cmd.mul_go) begin
      div_r <= sp_prod;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      div_r <= div_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.ax_mul) begin
      dprod_r <= dprod_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
    end
    if (cmd.out_ld) begin
      goal_x_r <= tgt_r[0];
      goal_y_r <= tgt_r[1];
      goal_z_r <= tgt_r[2];
      speed_r  <= pct_r;
    end
  end

  assign out_goal_x    = goal_x_r;
  assign out_goal_y    = goal_y_r;
  assign out_goal_z    = goal_z_r;
  assign out_speed_pct = speed_r;

endmodule

// ===== rtl/jvrl_ctrl.sv =====
module jvrl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_op,
  input  logic                   in_pose_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  jvrl_pkg::jvrl_status_t status,
  output jvrl_pkg::jvrl_cmd_t    cmd
);
  import jvrl_pkg::*;

  jvrl_state_t       state_r, state_nxt;
  logic [AXIS_W-1:0] ax_r, ax_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_axis;

  assign last_axis = (ax_r == AXIS_W'(NUM_AXES - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_op == OP_TICK) && in_pose_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:     state_nxt = ST_DIV;
      ST_DIV: begin
        if (status.div_last) begin
          state_nxt = ST_AX_MUL;
        end
      end
      ST_AX_MUL:  state_nxt = ST_AX_RAMP;
      ST_AX_RAMP: state_nxt = ST_AX_LEASH;
      ST_AX_LEASH: begin
        state_nxt = last_axis ? ST_EMIT : ST_AX_MUL;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd      = '0;
    cmd.axis = ax_r;
    case (state_r)
      ST_IDLE: begin
        cmd.frame_ld = in_valid && (in_op == OP_FRAME);
        cmd.tick_ld  = in_valid && (in_op == OP_TICK) && in_pose_valid;
      end
      ST_MUL:      cmd.mul_go   = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_AX_MUL:   cmd.ax_mul   = 1'b1;
      ST_AX_RAMP:  cmd.ax_ramp  = 1'b1;
      ST_AX_LEASH: cmd.ax_leash = 1'b1;
      ST_EMIT:     cmd.out_ld   = !out_valid_r || !out_stall;
      default:     cmd          = '0;
    endcase
  end

  // Axis counter and result valid.
  always_comb begin
    ax_nxt = ax_r;
    if (cmd.tick_ld) begin
      ax_nxt = '0;
    end else if (cmd.ax_leash && !last_axis) begin
      ax_nxt = ax_r + AXIS_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/jvrl_checker.sv =====
`include "assert_macros.svh"

module jvrl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_op,
  input logic                              in_pose_valid,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [jvrl_pkg::POS_W-1:0] out_goal_x,
  input logic signed [jvrl_pkg::POS_W-1:0] out_goal_y,
  input logic signed [jvrl_pkg::POS_W-1:0] out_goal_z,
  input logic [jvrl_pkg::PCT_W-1:0]        out_speed_pct
);
  import jvrl_pkg::*;

  // A stalled result stays valid and unchanged.
  `JV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_goal_x) && $stable(out_goal_y) && $stable(out_goal_z) && $stable(out_speed_pct), "stalled result changed")

  // The reported speed percentage stays within its limits.
  `JV_ASSERT(a_pct_range, clk, rst_n, !out_valid || (out_speed_pct >= PCT_MIN && out_speed_pct <= PCT_MAX), "speed percentage out of range")

  // A joystick frame never produces a result.
  `JV_ASSERT_NEXT(a_frame_silent, clk, rst_n, in_valid && !in_stall && (in_op == OP_FRAME), !$rose(out_valid), "frame produced a result")

  // A tick with a pose keeps the block busy on the next cycle.
  `JV_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_valid && !in_stall && (in_op == OP_TICK) && in_pose_valid, in_stall, "tick did not start work")

  // A new result only appears while a tick is being worked on.
  `JV_ASSERT(a_result_busy, clk, rst_n, !$rose(out_valid) || $past(in_stall), "result appeared while idle")

endmodule

bind jog_velocity_ramp_leash jvrl_checker u_jvrl_checker (.*);
